FILE: hdl/torch_height_voltage_regulator_unit_defines.svh
// Assertion macros shared by the torch height regulator RTL.
// No dependencies; the macros expect aclk and aresetn in the using module.
`ifndef TORCH_HEIGHT_VOLTAGE_REGULATOR_UNIT_DEFINES_SVH
`define TORCH_HEIGHT_VOLTAGE_REGULATOR_UNIT_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define THVR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("thvr: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define THVR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("thvr: next-cycle check failed");
`else
`define THVR_ASSERT_IMP(name, ante, cons)
`define THVR_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: hdl/thvr_pkg.sv
// Shared types and constants of the torch height voltage regulator.
// No dependencies; imported by every module of the block.
package thvr_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int VOLT_SAMPLES_DFLT = 100;
    localparam int CURR_SAMPLES_DFLT = 50;
    localparam int ADC_BITS_DFLT     = 10;

    // Port widths.
    localparam int SAMPLE_W  = 10;
    localparam int VOLT_W    = 10;
    localparam int THR_W     = 7;
    localparam int LEVEL_W   = 9;
    localparam int AMPS_W    = 8;
    localparam int APB_DW    = 32;
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = PADDR_W - 2;

    // Voltage scaling and regulation window.
    localparam int VSCALE   = 300;
    localparam int VSCALE_W = 9;
    localparam int VLOW     = 50;
    localparam int VHIGH    = 300;
    localparam int DEADBAND = 1;
    localparam int AMPS_MAX = 255;

    // Current conversion: five times the gain, and the offset, both in Q24.
    localparam int Q_FRAC = 24;
    localparam int GAIN_W = 33;
    localparam logic [GAIN_W-1:0] GAIN5_Q24  = 33'd4839387955;
    localparam logic [29:0]       OFFSET_Q24 = 30'd825942344;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_SET_VOLTAGE       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIN_HIGH          = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIN_LOW           = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ARC_BY_CURRENT    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CURRENT_THRESHOLD = 3'd4;

    typedef struct packed {
        logic [VOLT_W-1:0] set_voltage;
        logic [VOLT_W-1:0] win_high;
        logic [VOLT_W-1:0] win_low;
        logic              arc_by_current;
        logic [THR_W-1:0]  current_threshold;
    } thvr_cfg_t;

    localparam thvr_cfg_t CFG_RESET = '{
        set_voltage:       10'd0,
        win_high:          10'd300,
        win_low:           10'd80,
        arc_by_current:    1'b0,
        current_threshold: 7'd0
    };

    // Flags carried from the accumulator stage to the evaluation stage.
    typedef struct packed {
        logic v_done;
        logic c_done;
        logic c_pos;
        logic inhibit;
    } thvr_stage_t;

endpackage

FILE: hdl/torch_height_voltage_regulator_unit.sv
// Pipeline: two register stages; an accepted sample beat passes the stage register
// and then the result register. Throughput: one sample per cycle; s_ready
// drops only when both stages hold a beat and m_ready is low, so the sustained
// rate is set by the consumer. Each stage holds constant multiplies side by side
// (reciprocal divides, gain and scaling), an adder or subtractor and compares.
// Reset: synchronous, active low; all but the stage data and move flags resets.
module torch_height_voltage_regulator_unit #(
    parameter int VOLT_SAMPLES = thvr_pkg::VOLT_SAMPLES_DFLT,
    parameter int CURR_SAMPLES = thvr_pkg::CURR_SAMPLES_DFLT,
    parameter int ADC_BITS     = thvr_pkg::ADC_BITS_DFLT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Sample channel.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [thvr_pkg::SAMPLE_W-1:0]  s_sample,
    input  logic                           s_mode,
    input  logic                           s_inhibit,
    // Result channel.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [thvr_pkg::LEVEL_W-1:0]   m_tip_voltage,
    output logic [thvr_pkg::AMPS_W-1:0]    m_current_amps,
    output logic                           m_arc_ok,
    output logic                           m_move_up,
    output logic                           m_move_down,
    output logic                           m_voltage_updated,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [thvr_pkg::PADDR_W-1:0]   paddr,
    input  logic [thvr_pkg::APB_DW-1:0]    pwdata,
    output logic [thvr_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import thvr_pkg::*;

    localparam int CY_W = $clog2(CURR_SAMPLES) + GAIN_W - Q_FRAC;

    thvr_cfg_t           cfg;
    logic                take;
    logic                st_valid;
    thvr_stage_t         st_flags;
    logic [ADC_BITS-1:0] st_avg;
    logic [CY_W-1:0]     st_cy;

    // Configuration registers. Writes are only expected while the block is idle,
    // so both stages read them directly without any shadowing.
    thvr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // First stage: the accepted beat is added into the voltage or current sum.
    // On every accepted beat the voltage sum is divided by the sample count through
    // a reciprocal multiply, and the current sum is scaled by the fixed-point gain
    // with the offset removed; the next stage uses them when an average completes.
    thvr_accum #(
        .VOLT_SAMPLES (VOLT_SAMPLES),
        .CURR_SAMPLES (CURR_SAMPLES),
        .ADC_BITS     (ADC_BITS)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .s_mode    (s_mode),
        .s_inhibit (s_inhibit),
        .cfg       (cfg),
        .take      (take),
        .st_valid  (st_valid),
        .st_flags  (st_flags),
        .st_avg    (st_avg),
        .st_cy     (st_cy)
    );

    // Second stage: the average is scaled to volts and the current to amps,
    // the arc flag is updated and gated by inhibit, and the deadband around
    // the set voltage picks the move direction. The result register also holds
    // the voltage level, current level and arc flag between beats.
    thvr_eval #(
        .CURR_SAMPLES (CURR_SAMPLES),
        .ADC_BITS     (ADC_BITS)
    ) u_eval (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .st_valid          (st_valid),
        .st_flags          (st_flags),
        .st_avg            (st_avg),
        .st_cy             (st_cy),
        .take              (take),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_tip_voltage     (m_tip_voltage),
        .m_current_amps    (m_current_amps),
        .m_arc_ok          (m_arc_ok),
        .m_move_up         (m_move_up),
        .m_move_down       (m_move_down),
        .m_voltage_updated (m_voltage_updated)
    );

endmodule

FILE: hdl/thvr_regs.sv
// APB-style configuration registers of the torch height regulator.
// Depends on thvr_pkg for the register map and the configuration struct.
module thvr_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [thvr_pkg::PADDR_W-1:0]   paddr,
    input  logic [thvr_pkg::APB_DW-1:0]    pwdata,
    output logic [thvr_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    output thvr_pkg::thvr_cfg_t            cfg
);
    import thvr_pkg::*;

    thvr_cfg_t              cfg_reg;
    thvr_cfg_t              cfg_next;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[PADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_SET_VOLTAGE:       cfg_next.set_voltage       = pwdata[VOLT_W-1:0];
                REG_WIN_HIGH:          cfg_next.win_high          = pwdata[VOLT_W-1:0];
                REG_WIN_LOW:           cfg_next.win_low           = pwdata[VOLT_W-1:0];
                REG_ARC_BY_CURRENT:    cfg_next.arc_by_current    = pwdata[0];
                REG_CURRENT_THRESHOLD: cfg_next.current_threshold = pwdata[THR_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SET_VOLTAGE:       prdata = APB_DW'(cfg_reg.set_voltage);
            REG_WIN_HIGH:          prdata = APB_DW'(cfg_reg.win_high);
            REG_WIN_LOW:           prdata = APB_DW'(cfg_reg.win_low);
            REG_ARC_BY_CURRENT:    prdata = APB_DW'(cfg_reg.arc_by_current);
            REG_CURRENT_THRESHOLD: prdata = APB_DW'(cfg_reg.current_threshold);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/thvr_accum.sv
// Sample accumulators and first pipeline stage of the torch height regulator.
// Depends on thvr_pkg and the assertion macro header.
`include "torch_height_voltage_regulator_unit_defines.svh"
module thvr_accum #(
    parameter int VOLT_SAMPLES = thvr_pkg::VOLT_SAMPLES_DFLT,
    parameter int CURR_SAMPLES = thvr_pkg::CURR_SAMPLES_DFLT,
    parameter int ADC_BITS     = thvr_pkg::ADC_BITS_DFLT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [thvr_pkg::SAMPLE_W-1:0]          s_sample,
    input  logic                                   s_mode,
    input  logic                                   s_inhibit,
    input  thvr_pkg::thvr_cfg_t                    cfg,
    input  logic                                   take,
    output logic                                   st_valid,
    output thvr_pkg::thvr_stage_t                  st_flags,
    output logic [ADC_BITS-1:0]                    st_avg,
    output logic [$clog2(CURR_SAMPLES)+thvr_pkg::GAIN_W-thvr_pkg::Q_FRAC-1:0] st_cy
);
    import thvr_pkg::*;

    localparam int VCLOG  = $clog2(VOLT_SAMPLES);
    localparam int CCLOG  = $clog2(CURR_SAMPLES);
    localparam int VSUM_W = ADC_BITS + VCLOG;
    localparam int CSUM_W = ADC_BITS + CCLOG;
    localparam int VCNT_W = $clog2(VOLT_SAMPLES + 1);
    localparam int CCNT_W = $clog2(CURR_SAMPLES + 1);
    localparam int SX_W   = (ADC_BITS > SAMPLE_W) ? ADC_BITS : SAMPLE_W;
    // Reciprocal of the voltage sample count, exact for every reachable sum.
    localparam int     VK     = VSUM_W + VCLOG;
    localparam longint VRECIP = ((longint'(1) << VK) + VOLT_SAMPLES - 1) / VOLT_SAMPLES;
    localparam int     VP_W   = VSUM_W + VK + 1;
    // Current path: sum times five gains, minus offset times the full divisor.
    localparam int CP_W = CSUM_W + GAIN_W;
    localparam int CY_W = CCLOG + GAIN_W - Q_FRAC;
    localparam logic [CP_W-1:0] OFS_D =
        CP_W'((longint'(OFFSET_Q24) * CURR_SAMPLES) << ADC_BITS);

    logic [VSUM_W-1:0] vsum_reg, vsum_next;
    logic [VCNT_W-1:0] vcnt_reg, vcnt_next;
    logic [CSUM_W-1:0] csum_reg, csum_next;
    logic [CCNT_W-1:0] ccnt_reg, ccnt_next;
    logic              st_valid_reg, st_valid_next;
    thvr_stage_t       st_reg, st_next;
    logic [ADC_BITS-1:0] avg_reg, avg_next;
    logic [CY_W-1:0]   cy_reg, cy_next;

    logic                s_accept;
    logic [SX_W-1:0]     s_ext;
    logic [ADC_BITS-1:0] s_adc;
    logic [VSUM_W-1:0]   vtot;
    logic [CSUM_W-1:0]   ctot;
    logic                v_last;
    logic                c_last;
    logic [VP_W-1:0]     vprod;
    logic [CP_W-1:0]     cprod;
    logic [CP_W-1:0]     cdiff;

    assign s_ready  = !st_valid_reg || take;
    assign s_accept = s_valid && s_ready;
    assign s_ext    = SX_W'(s_sample);
    assign s_adc    = s_ext[ADC_BITS-1:0];
    assign vtot     = vsum_reg + VSUM_W'(s_adc);
    assign ctot     = csum_reg + CSUM_W'(s_adc);
    assign v_last   = (vcnt_reg == VCNT_W'(VOLT_SAMPLES - 1));
    assign c_last   = (ccnt_reg == CCNT_W'(CURR_SAMPLES - 1));
    assign vprod    = VP_W'(vtot) * VP_W'(VRECIP);
    assign cprod    = CP_W'(ctot) * CP_W'(GAIN5_Q24);
    assign cdiff    = cprod - OFS_D;

    always_comb begin
        vsum_next     = vsum_reg;
        vcnt_next     = vcnt_reg;
        csum_next     = csum_reg;
        ccnt_next     = ccnt_reg;
        st_next       = st_reg;
        avg_next      = avg_reg;
        cy_next       = cy_reg;
        st_valid_next = st_valid_reg;
        if (take) begin
            st_valid_next = 1'b0;
        end
        if (s_accept) begin
            st_valid_next   = 1'b1;
            st_next.v_done  = 1'b0;
            st_next.c_done  = 1'b0;
            st_next.c_pos   = cprod >= OFS_D;
            st_next.inhibit = s_inhibit;
            avg_next        = vprod[VK +: ADC_BITS];
            cy_next         = cdiff[ADC_BITS + Q_FRAC +: CY_W];
            if (!s_mode) begin
                st_next.v_done = v_last;
                vsum_next      = v_last ? '0 : vtot;
                vcnt_next      = v_last ? '0 : vcnt_reg + 1'b1;
            end else if (cfg.arc_by_current) begin
                st_next.c_done = c_last;
                csum_next      = c_last ? '0 : ctot;
                ccnt_next      = c_last ? '0 : ccnt_reg + 1'b1;
            end
            // In voltage-window mode the current accumulator stays empty.
            if (!cfg.arc_by_current) begin
                csum_next = '0;
                ccnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vsum_reg     <= '0;
            vcnt_reg     <= '0;
            csum_reg     <= '0;
            ccnt_reg     <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            vsum_reg     <= vsum_next;
            vcnt_reg     <= vcnt_next;
            csum_reg     <= csum_next;
            ccnt_reg     <= ccnt_next;
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        st_reg  <= st_next;
        avg_reg <= avg_next;
        cy_reg  <= cy_next;
    end

    assign st_valid = st_valid_reg;
    assign st_flags = st_reg;
    assign st_avg   = avg_reg;
    assign st_cy    = cy_reg;

    `THVR_ASSERT_NEXT(a_cur_cleared, s_accept && !cfg.arc_by_current, csum_reg == '0 && ccnt_reg == '0)
    `THVR_ASSERT_NEXT(a_done_excl, s_accept, !(st_reg.v_done && st_reg.c_done))
    `THVR_ASSERT_NEXT(a_vcnt_wrap, s_accept && !s_mode && v_last, vcnt_reg == '0 && st_reg.v_done)
    `THVR_ASSERT_NEXT(a_stage_hold, st_valid_reg && !take, st_valid_reg)

endmodule

FILE: hdl/thvr_eval.sv
// Level conversion, arc flag and move decision stage with the result register.
// Depends on thvr_pkg and the assertion macro header.
`include "torch_height_voltage_regulator_unit_defines.svh"
module thvr_eval #(
    parameter int CURR_SAMPLES = thvr_pkg::CURR_SAMPLES_DFLT,
    parameter int ADC_BITS     = thvr_pkg::ADC_BITS_DFLT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  thvr_pkg::thvr_cfg_t                    cfg,
    input  logic                                   st_valid,
    input  thvr_pkg::thvr_stage_t                  st_flags,
    input  logic [ADC_BITS-1:0]                    st_avg,
    input  logic [$clog2(CURR_SAMPLES)+thvr_pkg::GAIN_W-thvr_pkg::Q_FRAC-1:0] st_cy,
    output logic                                   take,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [thvr_pkg::LEVEL_W-1:0]           m_tip_voltage,
    output logic [thvr_pkg::AMPS_W-1:0]            m_current_amps,
    output logic                                   m_arc_ok,
    output logic                                   m_move_up,
    output logic                                   m_move_down,
    output logic                                   m_voltage_updated
);
    import thvr_pkg::*;

    localparam int     CCLOG  = $clog2(CURR_SAMPLES);
    localparam int     CY_W   = CCLOG + GAIN_W - Q_FRAC;
    localparam int     CK     = CY_W + CCLOG;
    localparam longint CRECIP = ((longint'(1) << CK) + CURR_SAMPLES - 1) / CURR_SAMPLES;
    localparam int     CQ_W   = CY_W + CK + 1;
    localparam int     VP_W   = ADC_BITS + VSCALE_W;
    localparam int     CMP_W  = VOLT_W + 1;

    // The tip, amps and arc registers double as the regulator state.
    logic               m_valid_reg, m_valid_next;
    logic [LEVEL_W-1:0] tip_reg, tip_next;
    logic [AMPS_W-1:0]  amps_reg, amps_next;
    logic               ok_reg, ok_next;
    logic               up_reg, up_next;
    logic               down_reg, down_next;
    logic               upd_reg;

    logic [VP_W-1:0]    vprod;
    logic [LEVEL_W-1:0] lvl_new;
    logic               win_ok;
    logic [CQ_W-1:0]    cprod;
    logic [CY_W-1:0]    amps_q;
    logic [AMPS_W-1:0]  amps_new;
    logic               in_band;
    logic [CMP_W-1:0]   lvl_x;
    logic [CMP_W-1:0]   set_x;

    assign take    = st_valid && (!m_valid_reg || m_ready);
    assign vprod   = VP_W'(st_avg) * VP_W'(VSCALE);
    assign lvl_new = vprod[ADC_BITS +: LEVEL_W];
    assign win_ok  = (VOLT_W'(lvl_new) >= cfg.win_low) &&
                     (VOLT_W'(lvl_new) <= cfg.win_high);
    assign cprod   = CQ_W'(st_cy) * CQ_W'(CRECIP);
    assign amps_q  = cprod[CK +: CY_W];

    always_comb begin
        amps_new = '0;
        if (st_flags.c_pos) begin
            amps_new = (amps_q > CY_W'(AMPS_MAX)) ? AMPS_W'(AMPS_MAX) : amps_q[AMPS_W-1:0];
        end
    end

    always_comb begin
        tip_next  = tip_reg;
        amps_next = amps_reg;
        ok_next   = ok_reg;
        if (st_flags.v_done) begin
            tip_next = lvl_new;
            if (!cfg.arc_by_current) begin
                ok_next = win_ok;
            end
        end
        if (st_flags.c_done) begin
            amps_next = amps_new;
            ok_next   = amps_new >= AMPS_W'(cfg.current_threshold);
        end
        if (st_flags.inhibit) begin
            ok_next = 1'b0;
        end
        in_band   = (tip_next >= LEVEL_W'(VLOW)) && (tip_next <= LEVEL_W'(VHIGH));
        lvl_x     = CMP_W'(tip_next);
        set_x     = CMP_W'(cfg.set_voltage);
        up_next   = ok_next && in_band && (set_x >= lvl_x + CMP_W'(DEADBAND + 1));
        down_next = ok_next && in_band && (lvl_x >= set_x + CMP_W'(DEADBAND + 1));
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            tip_reg     <= '0;
            amps_reg    <= '0;
            ok_reg      <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (take) begin
                tip_reg  <= tip_next;
                amps_reg <= amps_next;
                ok_reg   <= ok_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            up_reg   <= up_next;
            down_reg <= down_next;
            upd_reg  <= st_flags.v_done;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_tip_voltage     = tip_reg;
    assign m_current_amps    = amps_reg;
    assign m_arc_ok          = ok_reg;
    assign m_move_up         = up_reg;
    assign m_move_down       = down_reg;
    assign m_voltage_updated = upd_reg;

    `THVR_ASSERT_IMP(e_move_excl, m_valid_reg, !(up_reg && down_reg))
    `THVR_ASSERT_IMP(e_move_needs_arc, m_valid_reg && (up_reg || down_reg), ok_reg)
    `THVR_ASSERT_IMP(e_tip_range, 1'b1, tip_reg < LEVEL_W'(VSCALE))
    `THVR_ASSERT_NEXT(e_take_shows, take, m_valid_reg)

endmodule

FILE: sim/tb_torch_height_voltage_regulator_unit.sv
// Self-checking testbench for the torch height voltage regulator unit.
// Depends on thvr_pkg and torch_height_voltage_regulator_unit with its submodules.
// A built-in predictor tracks the averaging, arc-ok decision and torch moves.
module tb_torch_height_voltage_regulator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import thvr_pkg::*;

    // Behavior of the unit as specified, kept apart from the package on purpose.
    localparam int VOLT_AVG_LEN = 100;
    localparam int CURR_AVG_LEN = 50;
    localparam int CONV_BITS = 10;
    localparam int VOLT_FULL_SCALE = 300;
    localparam longint unsigned AMPS_GAIN_Q24 = 64'd967877591;
    localparam longint unsigned AMPS_OFFSET_Q24 = 64'd825942344;
    localparam int REGULATE_LOW = 50;
    localparam int REGULATE_HIGH = 300;
    localparam int HOLD_BAND = 1;

    // Run shape.
    localparam int SETUPS = 10;
    localparam int BEATS_PER_SETUP = 135;
    localparam int IDLE_PCT = 28;
    localparam int STALL_CYCLES = 400;
    localparam int PRESSURE_SETUP = 6;
    localparam int CALM_SETUP = 7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                mode;
        logic                inhibit;
    } sample_beat_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] tip_voltage;
        logic [AMPS_W-1:0]  current_amps;
        logic               arc_ok;
        logic               move_up;
        logic               move_down;
        logic               voltage_updated;
    } regulator_reading_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_sample = '0;
    logic                s_mode = 1'b0;
    logic                s_inhibit = 1'b0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [LEVEL_W-1:0] m_tip_voltage;
    logic [AMPS_W-1:0]  m_current_amps;
    logic               m_arc_ok;
    logic               m_move_up;
    logic               m_move_down;
    logic               m_voltage_updated;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // Stimulus waiting for the driver, and readings waiting for the block.
    sample_beat_t       pending_samples[$];
    regulator_reading_t expected_readings[$];

    // Predictor copy of the register file and of the accumulator state.
    thvr_cfg_t    cfg_now;
    logic [16:0]  volt_sum;
    logic [6:0]   volt_count;
    logic [15:0]  curr_sum;
    logic [5:0]   curr_count;
    logic [LEVEL_W-1:0] volt_level;
    logic [AMPS_W-1:0]  curr_level;
    logic         arc_flag;

    // Flow control shared between the sequencer and the two channel processes.
    logic calm = 1'b0;
    int   hold_req = 0;
    int   hold_done;
    int   hold_left;

    int mismatches = 0;
    int cycle_count = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int reg_writes = 0;
    int volt_averages = 0;
    int curr_averages = 0;
    int arc_beats = 0;
    int move_beats = 0;

    torch_height_voltage_regulator_unit DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample          (s_sample),
        .s_mode            (s_mode),
        .s_inhibit         (s_inhibit),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_tip_voltage     (m_tip_voltage),
        .m_current_amps    (m_current_amps),
        .m_arc_ok          (m_arc_ok),
        .m_move_up         (m_move_up),
        .m_move_down       (m_move_down),
        .m_voltage_updated (m_voltage_updated),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Amps from a current sum: gain times five over the full converter range, minus
    // the offset, all in Q24. A non-positive difference clamps to zero amps.
    function automatic logic [AMPS_W-1:0] amps_from_total(logic [15:0] total,
                                                          logic [5:0] count);
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        num = AMPS_GAIN_Q24 * 64'd5 * 64'(total);
        den = 64'(count) << CONV_BITS;
        q = num / den;
        if (q <= AMPS_OFFSET_Q24)
            return '0;
        q = (q - AMPS_OFFSET_Q24) >> 24;
        return (q > 64'd255) ? 8'd255 : q[7:0];
    endfunction

    // Advances the predictor by one sample beat and returns the reading it causes.
    function automatic regulator_reading_t predict_reading(logic [SAMPLE_W-1:0] raw,
                                                           logic is_current,
                                                           logic inhibit_in);
        regulator_reading_t r;
        int unsigned avg;
        int gap;
        r = '0;
        if (!is_current) begin
            volt_sum = volt_sum + raw;
            volt_count = volt_count + 1'b1;
        end else if (cfg_now.arc_by_current) begin
            curr_sum = curr_sum + raw;
            curr_count = curr_count + 1'b1;
        end
        // In voltage-window mode the current accumulator never holds anything.
        if (!cfg_now.arc_by_current) begin
            curr_sum = '0;
            curr_count = '0;
        end

        if (volt_count >= VOLT_AVG_LEN) begin
            avg = volt_sum / volt_count;
            volt_level = LEVEL_W'((avg * VOLT_FULL_SCALE) >> CONV_BITS);
            if (!cfg_now.arc_by_current)
                arc_flag = (volt_level >= cfg_now.win_low) &&
                           (volt_level <= cfg_now.win_high);
            volt_sum = '0;
            volt_count = '0;
            r.voltage_updated = 1'b1;
        end

        if (cfg_now.arc_by_current && curr_count >= CURR_AVG_LEN) begin
            curr_level = amps_from_total(curr_sum, curr_count);
            arc_flag = (curr_level >= cfg_now.current_threshold);
            curr_sum = '0;
            curr_count = '0;
            curr_averages++;
        end

        if (inhibit_in)
            arc_flag = 1'b0;

        // Height regulation only with an arc and a plausible voltage.
        if (arc_flag && volt_level >= REGULATE_LOW && volt_level <= REGULATE_HIGH) begin
            gap = int'(volt_level) - int'(cfg_now.set_voltage);
            if (gap < 0)
                gap = -gap;
            if (gap > HOLD_BAND) begin
                if (volt_level < cfg_now.set_voltage)
                    r.move_up = 1'b1;
                else
                    r.move_down = 1'b1;
            end
        end

        r.tip_voltage = volt_level;
        r.current_amps = curr_level;
        r.arc_ok = arc_flag;
        return r;
    endfunction

    // Prints one line per mismatch (the first few only) and counts every one.
    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ns: result beat %0d: %s", $time, beats_checked, msg);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Sample driver. The predictor runs on the beat accepted at this edge, and a new
    // beat is loaded only when the slot is empty or is being taken.
    always @(posedge aclk) begin : sample_driver
        sample_beat_t beat;
        if (!aresetn) begin
            s_valid <= 1'b0;
            volt_sum = '0;
            volt_count = '0;
            curr_sum = '0;
            curr_count = '0;
            volt_level = '0;
            curr_level = '0;
            arc_flag = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_readings.push_back(predict_reading(s_sample, s_mode, s_inhibit));
                beats_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_samples.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    beat = pending_samples.pop_front();
                    s_sample <= beat.sample;
                    s_mode <= beat.mode;
                    s_inhibit <= beat.inhibit;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the sequencer can keep feeding beats.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 0;
        end else if (hold_req != hold_done) begin
            hold_left <= STALL_CYCLES;
            hold_done <= hold_req;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: every accepted beat is compared with the oldest expectation.
    always @(posedge aclk) begin : result_monitor
        regulator_reading_t got;
        regulator_reading_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_tip_voltage, m_current_amps, m_arc_ok, m_move_up, m_move_down,
                        m_voltage_updated};
                if (expected_readings.size() == 0) begin
                    report_mismatch("result beat arrived with nothing expected");
                end else begin
                    want = expected_readings.pop_front();
                    check_field("tip_voltage", got.tip_voltage, want.tip_voltage);
                    check_field("current_amps", got.current_amps, want.current_amps);
                    check_field("arc_ok", got.arc_ok, want.arc_ok);
                    check_field("move_up", got.move_up, want.move_up);
                    check_field("move_down", got.move_down, want.move_down);
                    check_field("voltage_updated", got.voltage_updated,
                                want.voltage_updated);
                    volt_averages += want.voltage_updated;
                    arc_beats += want.arc_ok;
                    move_beats += want.move_up | want.move_down;
                end
                beats_checked++;
            end
            m_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic queue_sample(int sample, logic mode, logic inhibit);
        sample_beat_t beat;
        beat.sample = SAMPLE_W'(sample);
        beat.mode = mode;
        beat.inhibit = inhibit;
        pending_samples.push_back(beat);
    endtask

    // One register write: setup cycle, access cycle, then the write edge.
    task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SET_VOLTAGE:       cfg_now.set_voltage = value[VOLT_W-1:0];
            REG_WIN_HIGH:          cfg_now.win_high = value[VOLT_W-1:0];
            REG_WIN_LOW:           cfg_now.win_low = value[VOLT_W-1:0];
            REG_ARC_BY_CURRENT:    cfg_now.arc_by_current = value[0];
            REG_CURRENT_THRESHOLD: cfg_now.current_threshold = value[THR_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Waits until every beat has been sent and answered, then adds a settling wait.
    task automatic wait_until_drained();
        while (pending_samples.size() != 0 || expected_readings.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Sequencer: directed beats first, then setups of random but structured traffic.
    initial begin : sequencer
        thvr_cfg_t next_cfg;
        int setup;
        int k;
        int v;
        int vcenter;
        int ccenter;
        int curr_pct;
        int inh_pct;
        logic is_current;

        cfg_now = CFG_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Field extremes, both modes, inhibit on and off, and alternating bit patterns.
        // With the reset setup, current beats must be thrown away.
        queue_sample(0, 1'b0, 1'b0);
        queue_sample(1023, 1'b0, 1'b0);
        queue_sample(1023, 1'b1, 1'b0);
        queue_sample(0, 1'b1, 1'b0);
        queue_sample(512, 1'b0, 1'b1);
        queue_sample(1, 1'b1, 1'b1);
        queue_sample('h2AA, 1'b0, 1'b0);
        queue_sample('h155, 1'b0, 1'b0);
        queue_sample('h3FF, 1'b0, 1'b1);
        queue_sample(0, 1'b0, 1'b1);
        queue_sample('h200, 1'b1, 1'b1);
        queue_sample('h1FF, 1'b1, 1'b0);
        wait_until_drained();

        for (setup = 0; setup < SETUPS; setup++) begin
            next_cfg.arc_by_current = (setup == 3 || setup == 4 || setup == 5 || setup == 8)
                                      ? 1'b1 : (setup > 5) ? 1'($urandom_range(1)) : 1'b0;
            next_cfg.win_low = VOLT_W'($urandom_range(150));
            next_cfg.win_high = VOLT_W'($urandom_range(999, 150));
            next_cfg.current_threshold = THR_W'($urandom_range(99));
            // Half the time the target sits right at the deadband edges of the level.
            if ($urandom_range(1)) begin
                v = int'(volt_level) + int'($urandom_range(4)) - 2;
                next_cfg.set_voltage = VOLT_W'((v < 0) ? 0 : v);
            end else begin
                next_cfg.set_voltage = VOLT_W'($urandom_range(999));
            end
            case (setup)
                0: begin
                    next_cfg.win_low = 10'd80;
                    next_cfg.win_high = 10'd300;
                end
                1: begin
                    // Inverted window: the voltage test can never pass.
                    next_cfg.win_low = 10'd999;
                    next_cfg.win_high = 10'd0;
                end
                2: begin
                    next_cfg.win_low = 10'd0;
                    next_cfg.win_high = 10'd999;
                    next_cfg.set_voltage = 10'd999;
                end
                3: next_cfg.current_threshold = 7'd0;
                4: begin
                    next_cfg.current_threshold = 7'd99;
                    next_cfg.set_voltage = 10'd0;
                end
                default: ;
            endcase
            write_register(REG_SET_VOLTAGE, APB_DW'(next_cfg.set_voltage));
            write_register(REG_WIN_HIGH, APB_DW'(next_cfg.win_high));
            write_register(REG_WIN_LOW, APB_DW'(next_cfg.win_low));
            write_register(REG_ARC_BY_CURRENT, APB_DW'(next_cfg.arc_by_current));
            write_register(REG_CURRENT_THRESHOLD, APB_DW'(next_cfg.current_threshold));

            if (setup == PRESSURE_SETUP)
                hold_req <= hold_req + 1;
            calm <= (setup == CALM_SETUP);

            curr_pct = cfg_now.arc_by_current ? 45 : 20;
            inh_pct = (setup % 3 == 0) ? 0 : (setup % 3 == 1) ? 3 : 10;
            vcenter = 0;
            ccenter = 0;
            // Samples cluster around a center so averages land where the decisions
            // are interesting; a tenth of the beats are plain noise.
            for (k = 0; k < BEATS_PER_SETUP; k++) begin
                if (k % 50 == 0) begin
                    vcenter = ($urandom_range(99) < 80) ? $urandom_range(1023, 180)
                                                        : $urandom_range(1023);
                    ccenter = ($urandom_range(99) < 80) ? $urandom_range(650, 150)
                                                        : $urandom_range(1023);
                end
                is_current = ($urandom_range(99) < curr_pct);
                if ($urandom_range(99) < 10) begin
                    v = $urandom_range(1023);
                end else begin
                    v = (is_current ? ccenter : vcenter) + int'($urandom_range(16)) - 8;
                    v = (v < 0) ? 0 : (v > 1023) ? 1023 : v;
                end
                queue_sample(v, is_current, $urandom_range(99) < inh_pct);
            end
            wait_until_drained();
        end

        calm <= 1'b0;
        repeat (8) @(posedge aclk);
        $display("ran %0d sample beats and %0d register writes across %0d setups",
                 beats_sent, reg_writes, SETUPS);
        $display("saw %0d voltage averages, %0d current averages, %0d arc-ok beats, %0d moves",
                 volt_averages, curr_averages, arc_beats, move_beats);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/thvr_pkg.sv
hdl/thvr_regs.sv
hdl/thvr_accum.sv
hdl/thvr_eval.sv
hdl/torch_height_voltage_regulator_unit.sv
sim/tb_torch_height_voltage_regulator_unit.sv
